// File: rtl/speck_pkg.sv
// ----------------------------------------------------------------------------
// speck_pkg: shared types and constants for the Speck128/256 cipher
// Word width, rotation amounts, configuration register indexes, command
// codes, controller states and the ARX helper functions.
// ----------------------------------------------------------------------------
package speck_pkg;

  localparam int WORD_W         = 64;
  localparam int ALPHA          = 8;
  localparam int BETA           = 3;
  localparam int NUM_ROUNDS_DEF = 34;
  localparam int KEY_WORDS_DEF  = 4;

  // Configuration port
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_NUM_REGS = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = CFG_INDEX_W'(3);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    word_t block_high;
    word_t block_low;
  } in_item_t;

  typedef struct packed {
    word_t out_high;
    word_t out_low;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_ROUND,
    ST_DONE
  } state_t;

  // Shift control for the round key chain
  typedef struct packed {
    logic fwd;  // every cell takes its upper neighbor
    logic bwd;  // every cell takes its lower neighbor
  } key_shift_t;

  function automatic word_t rotr(input word_t v, input int unsigned s);
    rotr = (v >> s) | (v << (WORD_W - s));
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned s);
    rotl = (v << s) | (v >> (WORD_W - s));
  endfunction

endpackage

// File: rtl/speck_stream_if.sv
// ----------------------------------------------------------------------------
// speck_stream_if: valid/ready channel
// Carries one payload item per transaction from source to sink.
// ----------------------------------------------------------------------------
interface speck_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/speck_key_cell.sv
// ----------------------------------------------------------------------------
// speck_key_cell: one round key slot of the key chain
// Holds one 64-bit round key and takes a neighbor's key when the chain
// shifts in either direction.
// ----------------------------------------------------------------------------
module speck_key_cell (
  input  logic                 clk,
  input  speck_pkg::key_shift_t shift,
  input  speck_pkg::word_t     from_hi,
  input  speck_pkg::word_t     from_lo,
  output speck_pkg::word_t     key
);
  import speck_pkg::*;

  // Take the upper or lower neighbor, else hold
  always_ff @(posedge clk) begin
    if (shift.fwd) begin
      key <= from_hi;
    end else if (shift.bwd) begin
      key <= from_lo;
    end
  end

endmodule

// File: rtl/speck_sched.sv
// ----------------------------------------------------------------------------
// speck_sched: key schedule generator
// Produces one round key per step from the key words, keeping the l words
// in a short queue.
// ----------------------------------------------------------------------------
module speck_sched #(
  parameter int KEY_WORDS  = speck_pkg::KEY_WORDS_DEF,
  parameter int NUM_ROUNDS = speck_pkg::NUM_ROUNDS_DEF,
  localparam int CNT_W     = $clog2(NUM_ROUNDS)
) (
  input  logic                                       clk,
  input  logic                                       load,
  input  logic                                       step,
  input  logic [KEY_WORDS-1:0][speck_pkg::WORD_W-1:0] key_in,
  input  logic [CNT_W-1:0]                           idx,
  output speck_pkg::word_t                           k
);
  import speck_pkg::*;

  word_t lq [KEY_WORDS-1];
  word_t new_l;

  // Next l word from the current round key and the queue head
  assign new_l = (k + rotr(lq[0], ALPHA)) ^ WORD_W'(idx);

  // Load the key words, or advance one schedule step
  always_ff @(posedge clk) begin
    if (load) begin
      k <= key_in[0];
      for (int j = 0; j < KEY_WORDS - 1; j++) begin
        lq[j] <= key_in[j+1];
      end
    end else if (step) begin
      k <= rotl(k, BETA) ^ new_l;
      for (int j = 0; j < KEY_WORDS - 2; j++) begin
        lq[j] <= lq[j+1];
      end
      lq[KEY_WORDS-2] <= new_l;
    end
  end

endmodule

// File: rtl/speck_round.sv
// ----------------------------------------------------------------------------
// speck_round: ARX round datapath
// Holds the block halves and applies one encryption or decryption round
// per step.
// ----------------------------------------------------------------------------
module speck_round (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic             dec,
  input  speck_pkg::word_t key,
  input  speck_pkg::word_t in_x,
  input  speck_pkg::word_t in_y,
  output speck_pkg::word_t x,
  output speck_pkg::word_t y
);
  import speck_pkg::*;

  word_t enc_x;
  word_t enc_y;
  word_t dec_x;
  word_t dec_y;

  // Forward and inverse round
  always_comb begin
    enc_x = (rotr(x, ALPHA) + y) ^ key;
    enc_y = rotl(y, BETA) ^ enc_x;
    dec_y = rotr(x ^ y, BETA);
    dec_x = rotl((x ^ key) - dec_y, ALPHA);
  end

  // Load a new block or advance one round
  always_ff @(posedge clk) begin
    if (load) begin
      x <= in_x;
      y <= in_y;
    end else if (step) begin
      x <= dec ? dec_x : enc_x;
      y <= dec ? dec_y : enc_y;
    end
  end

endmodule

// File: rtl/speck128_256_block_cipher_top.sv
// ----------------------------------------------------------------------------
// speck128_256_block_cipher_top: Speck128/256 block cipher
// Key expansion into a chain of round key cells and a one-round-per-cycle
// ARX core for encryption and decryption.
// ----------------------------------------------------------------------------
//  channel   dir  payload                         transfer
//  blk_in    in   cmd, block_high, block_low      valid & ready
//  blk_out   out  out_high, out_low               valid & ready
//  cfg       in   cfg_index, cfg_data             cfg_we
//
//  A block is accepted, takes one ARX round per cycle in the round state,
//  then moves into the output register. The first block after reset or a
//  key write first expands the key, shifting each round key into the chain.
//  The round key chain rotates once per round, so only one key is read per
//  cycle. A result waiting in the output register does not stop the next
//  block from entering; it stalls that block only in its finishing state.
//  Reset is synchronous; the round key chain is not reset.
// ----------------------------------------------------------------------------
module speck128_256_block_cipher_top #(
  parameter int NUM_ROUNDS = speck_pkg::NUM_ROUNDS_DEF,
  parameter int KEY_WORDS  = speck_pkg::KEY_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  speck_stream_if.sink                      blk_in,
  speck_stream_if.source                    blk_out,
  input  logic                              cfg_we,
  input  logic [speck_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  speck_pkg::word_t                  cfg_data
);
  import speck_pkg::*;

  localparam int CNT_W = $clog2(NUM_ROUNDS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_ROUNDS - 1);

  state_t state;
  state_t state_next;

  word_t            key_words [CFG_NUM_REGS];
  logic             keys_ready;
  logic             dec;
  logic [CNT_W-1:0] cnt;
  logic             out_valid;
  out_item_t        out_data;

  logic       accept;
  logic       in_ready;
  logic       sched_load;
  logic       sched_step;
  logic       rnd_load;
  logic       rnd_step;
  logic       out_load;
  key_shift_t shift;

  logic [KEY_WORDS-1:0][WORD_W-1:0] sched_keys;
  word_t sched_k;
  word_t tail_in;
  word_t cell_q  [NUM_ROUNDS];
  word_t cell_hi [NUM_ROUNDS];
  word_t cell_lo [NUM_ROUNDS];
  word_t rnd_key;
  word_t rnd_x;
  word_t rnd_y;

  assign accept        = blk_in.valid && in_ready;
  assign blk_in.ready  = in_ready;
  assign blk_out.valid = out_valid;
  assign blk_out.data  = out_data;

  // Key registers; any write in range invalidates the stored round keys
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < CFG_NUM_REGS; j++) begin
        key_words[j] <= '0;
      end
      keys_ready <= 1'b0;
    end else if (cfg_we && (cfg_index == CFG_KEY_WORD0 || cfg_index == CFG_KEY_WORD1 ||
                            cfg_index == CFG_KEY_WORD2 || cfg_index == CFG_KEY_WORD3)) begin
      key_words[cfg_index[1:0]] <= cfg_data;
      keys_ready                <= 1'b0;
    end else if (state == ST_EXPAND && cnt == LAST) begin
      keys_ready <= 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = keys_ready ? ST_ROUND : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (cnt == LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (cnt == LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || blk_out.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready   = 1'b0;
    sched_load = 1'b0;
    sched_step = 1'b0;
    rnd_load   = 1'b0;
    rnd_step   = 1'b0;
    out_load   = 1'b0;
    shift      = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        sched_load = accept;
        rnd_load   = accept;
      end
      ST_EXPAND: begin
        sched_step = 1'b1;
        shift.fwd  = 1'b1;
      end
      ST_ROUND: begin
        rnd_step  = 1'b1;
        shift.fwd = !dec;
        shift.bwd = dec;
      end
      ST_DONE: begin
        out_load = !out_valid || blk_out.ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // State, command and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      dec   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        dec <= (blk_in.data.cmd == CMD_DECRYPT);
      end
      if ((state == ST_EXPAND || state == ST_ROUND) && cnt != LAST) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Output register; hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (blk_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.out_high <= rnd_x;
      out_data.out_low  <= rnd_y;
    end
  end

  // Key schedule
  always_comb begin
    for (int j = 0; j < KEY_WORDS; j++) begin
      sched_keys[j] = key_words[j];
    end
  end

  speck_sched #(
    .KEY_WORDS  (KEY_WORDS),
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_sched (
    .clk    (clk),
    .load   (sched_load),
    .step   (sched_step),
    .key_in (sched_keys),
    .idx    (cnt),
    .k      (sched_k)
  );

  // Round key chain: forward shift moves keys toward cell 0 and feeds the
  // tail, backward shift rotates the other way for decryption
  assign tail_in = (state == ST_EXPAND) ? sched_k : cell_q[0];

  always_comb begin
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      cell_hi[i] = (i == NUM_ROUNDS - 1) ? tail_in : cell_q[(i + 1) % NUM_ROUNDS];
      cell_lo[i] = (i == 0) ? cell_q[NUM_ROUNDS - 1] : cell_q[(i + NUM_ROUNDS - 1) % NUM_ROUNDS];
    end
  end

  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
    speck_key_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .from_hi (cell_hi[g]),
      .from_lo (cell_lo[g]),
      .key     (cell_q[g])
    );
  end

  // Encryption reads the head of the chain, decryption the tail
  assign rnd_key = dec ? cell_q[NUM_ROUNDS - 1] : cell_q[0];

  speck_round u_round (
    .clk  (clk),
    .load (rnd_load),
    .step (rnd_step),
    .dec  (dec),
    .key  (rnd_key),
    .in_x (blk_in.data.block_high),
    .in_y (blk_in.data.block_low),
    .x    (rnd_x),
    .y    (rnd_y)
  );

endmodule

// File: verif/speck128_256_block_cipher_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// speck128_256_block_cipher_top_test: Speck128/256 cipher regression
// Drives blocks through the valid/ready input channel under several keys and
// compares every output block against an in-bench model of the key schedule
// and the encrypt/decrypt rounds. Covers the reset key, the published test
// key, all-zero and all-ones keys, partial key rewrites, writes to unused
// register indexes and a key kept across phases. Both channels idle in
// random bursts, with one long output hold-off that backs up the block.
// ----------------------------------------------------------------------------
module speck128_256_block_cipher_top_test;
  import speck_pkg::*;

  localparam int NUM_ROUNDS       = NUM_ROUNDS_DEF;
  localparam int KEY_WORDS        = KEY_WORDS_DEF;
  localparam int SETTLE_CYCLES    = 2 * NUM_ROUNDS + 12;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int RANDOM_PHASES    = 12;
  localparam int PHASE_BLOCKS     = 95;
  localparam int MAX_PRINTED      = 50;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW = CFG_INDEX_W'(CFG_NUM_REGS);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_TOP = '1;

  // Published Speck128/256 test vector
  localparam word_t TV_KEY0 = 64'h0706050403020100;
  localparam word_t TV_KEY1 = 64'h0f0e0d0c0b0a0908;
  localparam word_t TV_KEY2 = 64'h1716151413121110;
  localparam word_t TV_KEY3 = 64'h1f1e1d1c1b1a1918;
  localparam word_t TV_PT_X = 64'h65736f6874206e49;
  localparam word_t TV_PT_Y = 64'h202e72656e6f6f70;
  localparam word_t TV_CT_X = 64'h4109010405c0f53e;
  localparam word_t TV_CT_Y = 64'h4eeeb48d9c188f43;
  localparam word_t ALL_ONES = '1;

  // --------------------------------------------------------------------------
  // Scoreboard: key registers, round key schedule and pending result blocks
  // --------------------------------------------------------------------------
  class speck_scoreboard;
    word_t       key_reg[CFG_NUM_REGS];
    word_t       round_key[NUM_ROUNDS];
    bit          schedule_valid;
    out_item_t   pending_blocks[$];
    int unsigned errors;

    function new();
      foreach (key_reg[i]) key_reg[i] = '0;
      schedule_valid = 1'b0;
      errors = 0;
    endfunction

    static function word_t ror(word_t v, int unsigned n);
      logic [2*WORD_W-1:0] both;
      both = {v, v} >> n;
      return both[WORD_W-1:0];
    endfunction

    static function word_t rol(word_t v, int unsigned n);
      return ror(v, WORD_W - n);
    endfunction

    task report_mismatch(input string msg);
      if (errors < MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // Unused indexes are ignored; any key write invalidates the schedule
    function void write_register(logic [CFG_INDEX_W-1:0] index, word_t value);
      if (index < CFG_NUM_REGS) begin
        key_reg[index[1:0]] = value;
        schedule_valid = 1'b0;
      end
    endfunction

    function void expand_round_keys();
      word_t lword[NUM_ROUNDS + KEY_WORDS];
      round_key[0] = key_reg[0];
      for (int i = 0; i < KEY_WORDS - 1; i++) lword[i] = key_reg[i + 1];
      for (int i = 0; i < NUM_ROUNDS - 1; i++) begin
        lword[i + KEY_WORDS - 1] = (round_key[i] + ror(lword[i], ALPHA)) ^ word_t'(i);
        round_key[i + 1] = rol(round_key[i], BETA) ^ lword[i + KEY_WORDS - 1];
      end
      schedule_valid = 1'b1;
    endfunction

    function out_item_t cipher_block(in_item_t blk);
      word_t     x;
      word_t     y;
      out_item_t res;
      x = blk.block_high;
      y = blk.block_low;
      if (blk.cmd == CMD_ENCRYPT) begin
        for (int i = 0; i < NUM_ROUNDS; i++) begin
          x = (ror(x, ALPHA) + y) ^ round_key[i];
          y = rol(y, BETA) ^ x;
        end
      end else begin
        for (int i = 0; i < NUM_ROUNDS; i++) begin
          y = ror(x ^ y, BETA);
          x = rol((x ^ round_key[NUM_ROUNDS - 1 - i]) - y, ALPHA);
        end
      end
      res.out_high = x;
      res.out_low  = y;
      return res;
    endfunction

    // Note an accepted input block and queue its expected result
    function void note_block(in_item_t blk);
      if (!schedule_valid) expand_round_keys();
      pending_blocks.push_back(cipher_block(blk));
    endfunction

    task check_block(input out_item_t got);
      out_item_t want;
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected result block %h %h", got.out_high, got.out_low));
      end else begin
        want = pending_blocks.pop_front();
        if (got.out_high !== want.out_high)
          report_mismatch($sformatf("out_high %h, expected %h", got.out_high, want.out_high));
        if (got.out_low !== want.out_low)
          report_mismatch($sformatf("out_low %h, expected %h", got.out_low, want.out_low));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block under test
  // --------------------------------------------------------------------------
  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  word_t                  cfg_data;

  speck_stream_if #(.payload_t(in_item_t))  blk_in_ch ();
  speck_stream_if #(.payload_t(out_item_t)) blk_out_ch ();

  speck_scoreboard sb = new;

  int unsigned src_gap_pct  = 0;
  int unsigned sink_gap_pct = 0;
  bit          long_hold_request = 1'b0;
  int unsigned stall_count = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  speck128_256_block_cipher_top dut (
    .clk       (clk),
    .rst       (rst),
    .blk_in    (blk_in_ch),
    .blk_out   (blk_out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------
  function automatic word_t pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return ALL_ONES;
      2: return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3: return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one block, hold it until accepted, then note it
  task automatic send_block(input cmd_t cmd, input word_t hi, input word_t lo);
    in_item_t item;
    item.cmd        = cmd;
    item.block_high = hi;
    item.block_low  = lo;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      blk_in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    blk_in_ch.valid <= 1'b1;
    blk_in_ch.data  <= item;
    do @(posedge clk); while (!blk_in_ch.ready);
    sb.note_block(item);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write
  task automatic write_key_word(input logic [CFG_INDEX_W-1:0] index, input word_t value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_register(index, value);
  endtask

  task automatic load_key(input word_t w0, input word_t w1, input word_t w2, input word_t w3);
    write_key_word(CFG_KEY_WORD0, w0);
    write_key_word(CFG_KEY_WORD1, w1);
    write_key_word(CFG_KEY_WORD2, w2);
    write_key_word(CFG_KEY_WORD3, w3);
    cfg_we <= 1'b0;
  endtask

  // Stop offering, wait for every pending block, then let the core go quiet
  task automatic wait_drained();
    blk_in_ch.valid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned key_mode;
    blk_in_ch.valid <= 1'b0;
    blk_in_ch.data  <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key (all zero), extremes of the block words
    send_block(CMD_ENCRYPT, '0, '0);
    send_block(CMD_DECRYPT, '0, '0);
    send_block(CMD_ENCRYPT, ALL_ONES, ALL_ONES);
    send_block(CMD_DECRYPT, ALL_ONES, ALL_ONES);
    wait_drained();

    // Published key and vector in both directions
    load_key(TV_KEY0, TV_KEY1, TV_KEY2, TV_KEY3);
    send_block(CMD_ENCRYPT, TV_PT_X, TV_PT_Y);
    send_block(CMD_DECRYPT, TV_CT_X, TV_CT_Y);
    send_block(CMD_ENCRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    send_block(CMD_DECRYPT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    send_block(CMD_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    wait_drained();

    // All-ones key; writes to unused indexes must leave it alone
    load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    write_key_word(CFG_UNUSED_LOW, {$urandom, $urandom});
    write_key_word(CFG_UNUSED_TOP, {$urandom, $urandom});
    cfg_we <= 1'b0;
    send_block(CMD_ENCRYPT, '0, '0);
    send_block(CMD_DECRYPT, ALL_ONES, ALL_ONES);
    send_block(CMD_ENCRYPT, ALL_ONES, '0);
    send_block(CMD_DECRYPT, '0, ALL_ONES);
    wait_drained();

    // Rewrite one word with its own value and clear another
    write_key_word(CFG_KEY_WORD2, ALL_ONES);
    write_key_word(CFG_KEY_WORD3, '0);
    cfg_we <= 1'b0;
    send_block(CMD_ENCRYPT, TV_PT_X, TV_PT_Y);
    send_block(CMD_DECRYPT, TV_CT_X, TV_CT_Y);
    wait_drained();

    // Random phases, each under its own key setting and idling mix
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      key_mode = $urandom_range(0, 5);
      case (key_mode)
        0: load_key({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
        1: begin
          write_key_word(CFG_INDEX_W'($urandom_range(0, CFG_NUM_REGS - 1)),
                         {$urandom, $urandom});
          cfg_we <= 1'b0;
        end
        2: ;  // keep the key and its expanded schedule
        3: load_key('0, '0, '0, '0);
        4: load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        default: begin
          write_key_word(CFG_KEY_WORD0, pick_word());
          write_key_word(CFG_KEY_WORD1, pick_word());
          write_key_word(CFG_INDEX_W'($urandom_range(CFG_NUM_REGS, 255)),
                         {$urandom, $urandom});
          write_key_word(CFG_KEY_WORD2, pick_word());
          write_key_word(CFG_KEY_WORD3, pick_word());
          cfg_we <= 1'b0;
        end
      endcase

      if (p == RANDOM_PHASES - 1) begin
        src_gap_pct  = 0;
        sink_gap_pct = 0;
      end else begin
        src_gap_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        sink_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end
      if (p == 2) long_hold_request = 1'b1;

      for (int n = 0; n < PHASE_BLOCKS; n++)
        send_block(cmd_t'($urandom_range(0, 1)), pick_word(), pick_word());
      wait_drained();
    end

    if (sb.pending_blocks.size() != 0)
      sb.report_mismatch($sformatf("%0d result blocks never arrived", sb.pending_blocks.size()));
    if (sb.errors == 0) begin
      $display("speck128_256_block_cipher_top regression: pass");
    end else begin
      $display("speck128_256_block_cipher_top regression: fail");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random ready bursts plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    blk_out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_request) begin
        blk_out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_request = 1'b0;
      end else if ($urandom_range(0, 99) < sink_gap_pct) begin
        blk_out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        blk_out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Check each result transaction against the oldest pending block
  always @(posedge clk) begin
    if (!rst && blk_out_ch.valid && blk_out_ch.ready) sb.check_block(blk_out_ch.data);
  end

  // Watchdog: end the run after too many cycles with no transaction
  always @(posedge clk) begin
    if (rst || cfg_we || (blk_in_ch.valid && blk_in_ch.ready)
        || (blk_out_ch.valid && blk_out_ch.ready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("speck128_256_block_cipher_top regression: fail");
      $finish;
    end
  end

endmodule

// File: speck128_256_block_cipher_top.f
rtl/speck_pkg.sv
rtl/speck_stream_if.sv
rtl/speck_key_cell.sv
rtl/speck_sched.sv
rtl/speck_round.sv
rtl/speck128_256_block_cipher_top.sv
verif/speck128_256_block_cipher_top_test.sv
